@@ src/bma_pkg.sv @@
// Shared types, constants and helpers for the boxcar moving average block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

	// Sizing
	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 16;
	localparam int LEN_W        = 7;
	localparam int LEN_RESET    = 3;
	localparam int SUM_W        = SAMPLE_WIDTH + 7;
	localparam int PTR_W        = $clog2(MAX_WINDOW);
	localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
	localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int DIV_STEPS    = SUM_W;
	localparam int DSTEP_W      = $clog2(DIV_STEPS + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]        sum_t;

	// One queued input transaction
	typedef struct packed {
		sample_t sample;
		logic    start_req;
	} item_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_UPD,
		B_DIV,
		B_OUT
	} back_state_t;

	// Clamp the programmed window length to 1..MAX_WINDOW
	function automatic logic [CNT_W-1:0] effective_len(input logic [LEN_W-1:0] wl);
		int l;
		l = int'(wl);
		if (l == 0) begin
			l = 1;
		end else if (l > MAX_WINDOW) begin
			l = MAX_WINDOW;
		end
		return CNT_W'(l);
	endfunction

endpackage

`default_nettype wire

@@ src/bma_front.sv @@
// Front end: takes input stream transactions, turns each into one item and
// queues them for the back end. Depends on bma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bma_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [bma_pkg::TDATA_W-1:0] s_axis_tdata,
	input  wire logic                       s_axis_tuser,
	output logic                            item_valid,
	output bma_pkg::item_t                  item,
	input  wire logic                       item_pop
);
	import bma_pkg::*;

	item_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     fill_q;
	logic                push;
	logic                pop;
	item_t               in_item;

	// Split the transaction into its fields
	always_comb begin
		in_item.sample    = sample_t'(s_axis_tdata[SAMPLE_WIDTH-1:0]);
		in_item.start_req = s_axis_tuser;
	end

	assign s_axis_tready = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = (fill_q != '0);
	assign pop           = item_pop && item_valid;
	assign item          = queue_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				fill_q <= (QPTR_W+1)'(fill_q + 1'b1);
			end else if (pop && !push) begin
				fill_q <= (QPTR_W+1)'(fill_q - 1'b1);
			end
		end
	end

	// Store queued items
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ src/bma_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on bma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bma_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bma_pkg::div_req_t req,
	output bma_pkg::div_rsp_t      rsp
);
	import bma_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DSTEP_W-1:0]  step_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [CNT_W:0]      shifted;
	logic                fits;
	logic [CNT_W-1:0]    rem_nxt;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		fits    = (shifted >= {1'b0, dvs_q});
		rem_nxt = fits ? CNT_W'(shifted - {1'b0, dvs_q}) : CNT_W'(shifted);
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= DSTEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= DSTEP_W'(step_q - 1'b1);
				if (step_q == DSTEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

@@ src/bma_back.sv @@
// Back end: sample ring, running sum, seen count and result sequencing.
// Depends on bma_pkg and bma_div.
`timescale 1ns / 1ps
`default_nettype none

module bma_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [bma_pkg::LEN_W-1:0] win_len,
	input  wire logic                      item_valid,
	input  wire bma_pkg::item_t            item,
	output logic                           item_pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output bma_pkg::sample_t               out_average,
	output logic                           out_full
);
	import bma_pkg::*;

	localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'(2**(SAMPLE_WIDTH-1) - 1);
	localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - (SUM_W+1)'(1);

	back_state_t        state_q;
	back_state_t        state_nxt;
	sample_t            ring [MAX_WINDOW];
	sample_t            rd_q;
	sample_t            sample_q;
	sum_t               sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wp_q;
	logic               neg_q;
	sample_t            avg_q;
	logic               full_q;

	logic [CNT_W-1:0]   len;
	logic [CNT_W:0]     wp_ext;
	logic [CNT_W:0]     len_ext;
	logic [PTR_W-1:0]   old_idx;
	logic               sub_old;
	sum_t               new_sum;
	logic [CNT_W-1:0]   count_inc;
	logic               full_nxt;
	logic [SUM_W-1:0]   sum_mag;
	logic signed [SUM_W:0] quo_signed;
	sample_t            quo_sat;
	logic               ring_rd;
	logic               ring_wr;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// Window length and the ring slot that leaves the window
	always_comb begin
		len     = effective_len(win_len);
		wp_ext  = (CNT_W+1)'(wp_q);
		len_ext = (CNT_W+1)'(len);
		if (wp_ext >= len_ext) begin
			old_idx = PTR_W'(wp_ext - len_ext);
		end else begin
			old_idx = PTR_W'(wp_ext + (CNT_W+1)'(MAX_WINDOW) - len_ext);
		end
	end

	// Running sum update and fill tracking
	always_comb begin
		sub_old   = (count_q >= len);
		new_sum   = sum_q + sum_t'(sample_q) - (sub_old ? sum_t'(rd_q) : sum_t'(0));
		count_inc = (count_q < CNT_W'(MAX_WINDOW)) ? CNT_W'(count_q + 1'b1) : count_q;
		full_nxt  = (count_inc >= len);
		sum_mag   = new_sum[SUM_W-1] ? SUM_W'(~new_sum + 1'b1) : SUM_W'(new_sum);
	end

	// Restore the sign and saturate to the sample range
	always_comb begin
		quo_signed = neg_q ? -$signed({1'b0, div_rsp.quotient})
		                   : $signed({1'b0, div_rsp.quotient});
		if (quo_signed > SAT_HI) begin
			quo_sat = sample_t'(SAT_HI);
		end else if (quo_signed < SAT_LO) begin
			quo_sat = sample_t'(SAT_LO);
		end else begin
			quo_sat = sample_t'(quo_signed);
		end
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_nxt        = state_q;
		item_pop         = 1'b0;
		ring_rd          = 1'b0;
		ring_wr          = 1'b0;
		out_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = sum_mag;
		div_req.divisor  = len;
		case (state_q)
			B_IDLE: begin
				if (item_valid) begin
					item_pop  = 1'b1;
					ring_rd   = 1'b1;
					state_nxt = B_UPD;
				end
			end
			B_UPD: begin
				ring_wr = 1'b1;
				if (full_nxt) begin
					div_req.start = 1'b1;
					state_nxt     = B_DIV;
				end else begin
					state_nxt = B_OUT;
				end
			end
			B_DIV: begin
				if (div_rsp.done) begin
					state_nxt = B_OUT;
				end
			end
			B_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nxt = B_IDLE;
				end
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequence state: sum, count, write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			wp_q    <= '0;
		end else begin
			if (item_pop && item.start_req) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (ring_wr) begin
				sum_q   <= new_sum;
				count_q <= count_inc;
				wp_q    <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : PTR_W'(wp_q + 1'b1);
			end
		end
	end

	// Sample ring: read the leaving slot, then write the new sample
	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring[wp_q] <= sample_q;
		end
		if (ring_rd) begin
			rd_q <= ring[old_idx];
		end
	end

	// Item payload and result register
	always_ff @(posedge clk) begin
		if (item_pop) begin
			sample_q <= item.sample;
		end
		if (ring_wr) begin
			full_q <= full_nxt;
			neg_q  <= new_sum[SUM_W-1];
			if (!full_nxt) begin
				avg_q <= sample_q;
			end
		end
		if (state_q == B_DIV && div_rsp.done) begin
			avg_q <= quo_sat;
		end
	end

	assign out_average = avg_q;
	assign out_full    = full_q;

	bma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

@@ src/boxcar_moving_average.sv @@
// Top level of the boxcar moving average filter: config register, front
// queue and back end. Depends on bma_pkg, bma_front and bma_back.
//
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: sample; tuser: start_req
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: average; tuser: window_full
//  cfg      | in        | cfg_wr_en                    | cfg_wr_data: window_len
//
// A copied sample (window not yet full) passes through the idle, update and
// output states of the back end; a true average also waits in the divide state
// while the bit-serial divider divides the running sum by the window length.
// Input transactions queue up to four deep while the back end is busy or its
// result waits on m_axis_tready. Reset clears sum, count, pointer and queue and
// sets window_len to 3; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module boxcar_moving_average (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [bma_pkg::TDATA_W-1:0] s_axis_tdata,  // [15:0] sample
	input  wire logic                        s_axis_tuser,  // [0] start_req
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [bma_pkg::TDATA_W-1:0]      m_axis_tdata,  // [15:0] average
	output logic                             m_axis_tuser,  // [0] window_full
	input  wire logic                        cfg_wr_en,
	input  wire logic [bma_pkg::LEN_W-1:0]   cfg_wr_data
);
	import bma_pkg::*;

	logic [LEN_W-1:0] win_len_q;
	logic             item_valid;
	item_t            item;
	logic             item_pop;
	sample_t          out_average;

	// Hold the window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= LEN_W'(LEN_RESET);
		end else if (cfg_wr_en) begin
			win_len_q <= cfg_wr_data;
		end
	end

	bma_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop)
	);

	bma_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.win_len     (win_len_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_average (out_average),
		.out_full    (m_axis_tuser)
	);

	// Pad the result to whole bytes
	assign m_axis_tdata = TDATA_W'($unsigned(out_average));

endmodule

`default_nettype wire
